>>> hdl/twr_pkg.sv
`timescale 1ns / 1ps

package twr_pkg;

  // frame buffer size, longer frames are clipped to this length
  localparam int unsigned RxBufferBytes = 128;
  localparam int unsigned HdrBytes      = 4;
  localparam int unsigned HdrTsBytes    = 12;

  // event codes
  localparam logic [2:0] FUNC_START      = 3'd0;
  localparam logic [2:0] FUNC_TX_DONE    = 3'd1;
  localparam logic [2:0] FUNC_RX_GOOD    = 3'd2;
  localparam logic [2:0] FUNC_RX_FAIL    = 3'd3;
  localparam logic [2:0] FUNC_START_LATE = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_SEND_POLL  = 2'd0;
  localparam logic [1:0] KIND_SEND_FINAL = 2'd1;
  localparam logic [1:0] KIND_RECORD     = 2'd2;
  localparam logic [1:0] KIND_NOTICE     = 2'd3;

  // frame type byte of a response
  localparam logic [7:0] MSG_TYPE_RESP = 8'h02;

  // configuration register indexes
  localparam logic [1:0] REG_FINAL_DELAY   = 2'd0;
  localparam logic [1:0] REG_ANTENNA_DELAY = 2'd1;
  localparam logic [1:0] REG_NOTICE_PERIOD = 2'd2;

  // configuration reset values
  localparam logic [31:0] FINAL_DELAY_RST   = 32'd19169400;
  localparam logic [15:0] ANTENNA_DELAY_RST = 16'd0;
  localparam logic [7:0]  NOTICE_PERIOD_RST = 8'd10;

  typedef struct packed {
    logic [2:0]  func;
    logic [39:0] tx_timestamp;
    logic [39:0] rx_timestamp;
    logic [9:0]  rx_length;
    logic [7:0]  rx_type;
    logic [7:0]  rx_seq;
    logic [63:0] rx_remote_time;
  } event_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_seq;
    logic [31:0] delayed_tx_word;
    logic [39:0] poll_tx_time;
    logic [39:0] resp_rx_time;
    logic [63:0] remote_resp_tx_time;
    logic [40:0] final_tx_time;
  } result_t;

  typedef struct packed {
    logic [31:0] final_delay_dtu;
    logic [15:0] antenna_delay;
    logic [7:0]  notice_period;
  } cfg_t;

  // handshake between the event register and the engine
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

>>> hdl/twr_cfg_regs.sv
`timescale 1ns / 1ps

module twr_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output twr_pkg::cfg_t cfg
);
  import twr_pkg::*;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register file, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.final_delay_dtu <= FINAL_DELAY_RST;
      cfg.antenna_delay   <= ANTENNA_DELAY_RST;
      cfg.notice_period   <= NOTICE_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FINAL_DELAY:   cfg.final_delay_dtu <= cfg_data;
        REG_ANTENNA_DELAY: cfg.antenna_delay   <= cfg_data[15:0];
        REG_NOTICE_PERIOD: cfg.notice_period   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/twr_in_stage.sv
`timescale 1ns / 1ps

module twr_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                ev_valid,
  output logic                ev_stall,
  input  twr_pkg::event_t     ev_data,
  input  logic                advance,
  output twr_pkg::stage_ctl_t ctl_unused_guard,
  output logic                held_valid,
  output twr_pkg::event_t     held_data
);
  import twr_pkg::*;

  logic accept;

  // hold off the sender while the held event cannot move on
  assign ev_stall = held_valid && !advance;
  assign accept   = ev_valid && !ev_stall;

  assign ctl_unused_guard.valid   = held_valid;
  assign ctl_unused_guard.advance = advance;

  // event register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_data <= ev_data;
    end
  end

endmodule

>>> hdl/twr_engine.sv
`timescale 1ns / 1ps

module twr_engine (
  input  logic                clk,
  input  logic                rst,
  input  twr_pkg::cfg_t       cfg,
  input  twr_pkg::stage_ctl_t ctl,
  input  twr_pkg::event_t     ev,
  input  logic                out_free,
  output logic                advance,
  output logic                fire,
  output twr_pkg::result_t    result
);
  import twr_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_POLL_TX,
    PH_WAIT_RESP,
    PH_FINAL_TX
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  seq_num, seq_num_next;
  logic [39:0] poll_time, poll_time_next;
  logic [39:0] resp_time, resp_time_next;
  logic [63:0] remote_time, remote_time_next;
  logic [40:0] final_time, final_time_next;
  logic [7:0]  miss_count, miss_count_next;

  logic        has_res;
  logic [9:0]  len_clip;
  logic        frame_ok;
  logic [40:0] delay_sum;
  logic [31:0] word;
  logic [7:0]  period;
  logic [7:0]  miss_inc;
  logic        miss;

  // frame length clipped to the receive buffer
  assign len_clip = (ev.rx_length > 10'(RxBufferBytes)) ? 10'(RxBufferBytes)
                                                          : ev.rx_length;
  assign frame_ok = (len_clip >= 10'(HdrBytes)) && (ev.rx_type == MSG_TYPE_RESP)
                    && (ev.rx_seq == seq_num);

  // delayed final word and the predicted final transmit time
  assign delay_sum = {1'b0, ev.rx_timestamp} + {9'd0, cfg.final_delay_dtu};
  assign word      = delay_sum[39:8];

  // miss counter wraps at the notice period, zero period acts as one
  assign period   = (cfg.notice_period == 8'd0) ? 8'd1 : cfg.notice_period;
  assign miss_inc = miss_count + 8'd1;

  // next state and result for the held event
  always_comb begin
    phase_next       = phase;
    seq_num_next     = seq_num;
    poll_time_next   = poll_time;
    resp_time_next   = resp_time;
    remote_time_next = remote_time;
    final_time_next  = final_time;
    miss_count_next  = miss_count;
    has_res          = 1'b0;
    miss             = 1'b0;
    result           = '0;
    result.out_seq   = seq_num;

    case (ev.func)
      FUNC_START: begin
        if (phase == PH_IDLE) begin
          has_res     = 1'b1;
          result.kind = KIND_SEND_POLL;
          phase_next  = PH_POLL_TX;
        end
      end
      FUNC_TX_DONE: begin
        if (phase == PH_POLL_TX) begin
          poll_time_next = ev.tx_timestamp;
          phase_next     = PH_WAIT_RESP;
        end else if (phase == PH_FINAL_TX) begin
          has_res                    = 1'b1;
          result.kind                = KIND_RECORD;
          result.poll_tx_time        = poll_time;
          result.resp_rx_time        = resp_time;
          result.remote_resp_tx_time = remote_time;
          result.final_tx_time       = final_time;
          seq_num_next               = seq_num + 8'd1;
          phase_next                 = PH_IDLE;
        end
      end
      FUNC_RX_GOOD: begin
        if (phase == PH_WAIT_RESP) begin
          if (!frame_ok) begin
            miss = 1'b1;
          end else begin
            resp_time_next   = ev.rx_timestamp;
            remote_time_next = (len_clip >= 10'(HdrTsBytes)) ? ev.rx_remote_time
                                                             : 64'd0;
            final_time_next  = {1'b0, word[31:1], 9'd0} + {25'd0, cfg.antenna_delay};
            has_res                    = 1'b1;
            result.kind                = KIND_SEND_FINAL;
            result.delayed_tx_word     = word;
            result.poll_tx_time        = poll_time;
            result.resp_rx_time        = resp_time_next;
            result.remote_resp_tx_time = remote_time_next;
            result.final_tx_time       = final_time_next;
            phase_next                 = PH_FINAL_TX;
          end
        end
      end
      FUNC_RX_FAIL: begin
        if (phase == PH_POLL_TX || phase == PH_WAIT_RESP) begin
          miss = 1'b1;
        end
      end
      FUNC_START_LATE: begin
        if (phase == PH_FINAL_TX) begin
          seq_num_next = seq_num + 8'd1;
          phase_next   = PH_IDLE;
        end
      end
      default: ;
    endcase

    // missed exchange, notice on the first miss of each period
    if (miss) begin
      if (miss_count == 8'd0) begin
        has_res     = 1'b1;
        result.kind = KIND_NOTICE;
      end
      miss_count_next = (miss_inc >= period) ? 8'd0 : miss_inc;
      seq_num_next    = seq_num + 8'd1;
      phase_next      = PH_IDLE;
    end
  end

  // an event moves on unless its result finds the output register holding a stalled result
  assign advance = ctl.valid && (!has_res || out_free);
  assign fire    = advance && has_res;

  // exchange state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      seq_num     <= 8'd0;
      poll_time   <= 40'd0;
      resp_time   <= 40'd0;
      remote_time <= 64'd0;
      final_time  <= 41'd0;
      miss_count  <= 8'd0;
    end else if (advance) begin
      phase       <= phase_next;
      seq_num     <= seq_num_next;
      poll_time   <= poll_time_next;
      resp_time   <= resp_time_next;
      remote_time <= remote_time_next;
      final_time  <= final_time_next;
      miss_count  <= miss_count_next;
    end
  end

`ifndef SYNTHESIS
  a_fire_needs_event: assert property (@(posedge clk) disable iff (rst)
    fire |-> ctl.valid && advance)
    else $error("result issued without a held event");

  a_poll_enters_tx: assert property (@(posedge clk) disable iff (rst)
    fire && result.kind == KIND_SEND_POLL |=> phase == PH_POLL_TX)
    else $error("poll request did not enter poll transmit phase");

  a_miss_count_bound: assert property (@(posedge clk) disable iff (rst)
    advance && miss |=> miss_count < period || miss_count == 8'd0)
    else $error("miss counter passed the notice period");
`endif

endmodule

>>> hdl/twr_out_stage.sv
`timescale 1ns / 1ps

module twr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  twr_pkg::result_t result,
  output logic             out_free,
  output logic             res_valid,
  input  logic             res_stall,
  output twr_pkg::result_t res_data
);
  import twr_pkg::*;

  logic take;

  assign take     = res_valid && !res_stall;
  assign out_free = !res_valid || !res_stall;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(load && res_valid && res_stall))
    else $error("waiting result overwritten");
`endif

endmodule

>>> hdl/twr_ranging_initiator.sv
`timescale 1ns / 1ps

// initiator side of double-sided two-way ranging, fed one radio event per transfer
// event channel: ev_valid / ev_stall / ev_data; ev_data carries the event code,
//   transmit and receive timestamps and the decoded response frame fields
// result channel: res_valid / res_stall / res_data; at most one result per event:
//   send poll, send final (delayed), ranging record or no-response notice
// config channel: cfg_valid / cfg_ready / cfg_index / cfg_data, ready is always high;
//   index 0 final delay, 1 antenna delay, 2 notice period; write only while idle
// an event is first registered in the event register, and its result is then loaded
//   into the result register, which drives res_valid
// throughput: one event per cycle unless a result stalls; combinational compare/add
// a stalled result is held; events still flow while they make no result, and an
//   event that makes one waits in the event register until the result register frees
// reset (synchronous, rst high) empties both registers, returns to idle with
//   sequence and miss count zero and loads the default configuration
module twr_ranging_initiator (
  input  logic             clk,
  input  logic             rst,
  input  logic             ev_valid,
  output logic             ev_stall,
  input  twr_pkg::event_t  ev_data,
  output logic             res_valid,
  input  logic             res_stall,
  output twr_pkg::result_t res_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import twr_pkg::*;

  cfg_t       cfg;
  stage_ctl_t ctl;
  logic       held_valid;
  event_t     held_data;
  logic       advance;
  logic       fire;
  logic       out_free;
  result_t    result;

  twr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  twr_in_stage u_in (
    .clk              (clk),
    .rst              (rst),
    .ev_valid         (ev_valid),
    .ev_stall         (ev_stall),
    .ev_data          (ev_data),
    .advance          (advance),
    .ctl_unused_guard (ctl),
    .held_valid       (held_valid),
    .held_data        (held_data)
  );

  twr_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .ctl      (ctl),
    .ev       (held_data),
    .out_free (out_free),
    .advance  (advance),
    .fire     (fire),
    .result   (result)
  );

  twr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .result    (result),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

`ifndef SYNTHESIS
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    ev_stall |-> held_valid && !out_free)
    else $error("event side stalled with a free path");
`endif

endmodule

>>> sim/twr_ranging_initiator_tb.sv
`timescale 1ns / 1ps

module twr_ranging_initiator_tb;
  import twr_pkg::*;

  // event codes the block must ignore
  localparam logic [2:0] FUNC_UNDEF_LO = 3'd5;
  localparam logic [2:0] FUNC_UNDEF_HI = 3'd7;
  // register index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // cycles to let the block settle once nothing is expected
  localparam int SETTLE_CYCLES = 6;

  typedef enum logic [1:0] {PH_IDLE, PH_POLL_TX, PH_WAIT_RESP, PH_FINAL_TX} phase_t;

  typedef struct packed {
    event_t  ev;
    bit      typed;
    result_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        ev_valid = 1'b0;
  event_t      ev_data = '0;
  logic        ev_stall;
  logic        res_valid;
  logic        res_stall = 1'b0;
  result_t     res_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // ranging state tracked alongside the block
  phase_t      st_phase = PH_IDLE;
  logic [7:0]  st_seq = '0;
  logic [39:0] st_poll = '0;
  logic [39:0] st_resp = '0;
  logic [63:0] st_remote = '0;
  logic [40:0] st_final = '0;
  logic [7:0]  st_misses = '0;
  logic [31:0] reg_delay = FINAL_DELAY_RST;
  logic [15:0] reg_antenna = ANTENNA_DELAY_RST;
  logic [7:0]  reg_period = NOTICE_PERIOD_RST;

  result_t     radio_cmds_q[$];
  result_t     want_res;
  row_t        script[$];
  int          error_count = 0;
  int          items_sent = 0;
  int          next_gap = 0;
  bit          ev_held = 1'b0;
  bit          calm = 1'b0;
  int          stall_left = 0;
  int          stall_draw;
  int          phase_no;
  int          start_items;
  int          exchanges;

  twr_ranging_initiator uut (
    .clk(clk),
    .rst(rst),
    .ev_valid(ev_valid),
    .ev_stall(ev_stall),
    .ev_data(ev_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic event_t rand_event(input logic [2:0] f);
    event_t e;
    e.func           = f;
    e.tx_timestamp   = 40'({$urandom, $urandom});
    e.rx_timestamp   = 40'({$urandom, $urandom});
    e.rx_length      = 10'($urandom);
    e.rx_type        = 8'($urandom);
    e.rx_seq         = 8'($urandom);
    e.rx_remote_time = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) e.tx_timestamp = '1;
    if ($urandom_range(0, 7) == 0) e.rx_timestamp = '1;
    return e;
  endfunction

  function automatic event_t mk_event(input logic [2:0] f, input logic [39:0] tx,
                                      input logic [39:0] rx, input logic [9:0] len,
                                      input logic [7:0] mtype, input logic [7:0] seq,
                                      input logic [63:0] remote);
    event_t e;
    e.func           = f;
    e.tx_timestamp   = tx;
    e.rx_timestamp   = rx;
    e.rx_length      = len;
    e.rx_type        = mtype;
    e.rx_seq         = seq;
    e.rx_remote_time = remote;
    return e;
  endfunction

  function automatic result_t plain_result(input logic [1:0] kind, input logic [7:0] seq);
    result_t r;
    r         = '0;
    r.kind    = kind;
    r.out_seq = seq;
    return r;
  endfunction

  function automatic result_t with_times(input result_t base);
    result_t r;
    r                     = base;
    r.poll_tx_time        = st_poll;
    r.resp_rx_time        = st_resp;
    r.remote_resp_tx_time = st_remote;
    r.final_tx_time       = st_final;
    return r;
  endfunction

  // missed exchange: notice on the first miss of each period, then next sequence
  task automatic count_miss(output bit got, output result_t r);
    logic [7:0] period;
    period = (reg_period == 8'd0) ? 8'd1 : reg_period;
    got    = 1'b0;
    r      = '0;
    if (st_misses == 8'd0) begin
      got = 1'b1;
      r   = plain_result(KIND_NOTICE, st_seq);
    end
    st_misses = st_misses + 8'd1;
    if (st_misses >= period) st_misses = '0;
    st_seq   = st_seq + 8'd1;
    st_phase = PH_IDLE;
  endtask

  // next ranging state and radio command for one event
  task automatic predict_event(input event_t e, output bit got, output result_t r);
    logic [9:0]  len;
    logic [40:0] sum;
    logic [31:0] word;
    got = 1'b0;
    r   = '0;
    len = (e.rx_length > RxBufferBytes) ? 10'(RxBufferBytes) : e.rx_length;
    case (e.func)
      FUNC_START: begin
        if (st_phase == PH_IDLE) begin
          got      = 1'b1;
          r        = plain_result(KIND_SEND_POLL, st_seq);
          st_phase = PH_POLL_TX;
        end
      end
      FUNC_TX_DONE: begin
        if (st_phase == PH_POLL_TX) begin
          st_poll  = e.tx_timestamp;
          st_phase = PH_WAIT_RESP;
        end else if (st_phase == PH_FINAL_TX) begin
          got      = 1'b1;
          r        = with_times(plain_result(KIND_RECORD, st_seq));
          st_seq   = st_seq + 8'd1;
          st_phase = PH_IDLE;
        end
      end
      FUNC_RX_GOOD: begin
        if (st_phase == PH_WAIT_RESP) begin
          if (len < HdrBytes || e.rx_type != MSG_TYPE_RESP || e.rx_seq != st_seq) begin
            count_miss(got, r);
          end else begin
            st_resp   = e.rx_timestamp;
            st_remote = (len >= HdrTsBytes) ? e.rx_remote_time : 64'd0;
            sum       = {1'b0, st_resp} + {9'd0, reg_delay};
            word      = sum[39:8];
            st_final  = 41'({word[31:1], 1'b0, 8'h00}) + 41'(reg_antenna);
            got       = 1'b1;
            r         = with_times(plain_result(KIND_SEND_FINAL, st_seq));
            r.delayed_tx_word = word;
            st_phase  = PH_FINAL_TX;
          end
        end
      end
      FUNC_RX_FAIL: begin
        if (st_phase == PH_POLL_TX || st_phase == PH_WAIT_RESP) count_miss(got, r);
      end
      FUNC_START_LATE: begin
        if (st_phase == PH_FINAL_TX) begin
          st_seq   = st_seq + 8'd1;
          st_phase = PH_IDLE;
        end
      end
      default: ;
    endcase
  endtask

  // one event transfer; valid stays high when the next event follows at once
  task automatic send_event(input event_t e, input bit typed, input result_t typed_res);
    bit      got;
    result_t r;
    if (next_gap > 0) repeat (next_gap) @(posedge clk);
    ev_valid <= 1'b1;
    ev_data  <= e;
    @(posedge clk);
    while (ev_stall) @(posedge clk);
    predict_event(e, got, r);
    if (got) radio_cmds_q.push_back(typed ? typed_res : r);
    items_sent++;
    next_gap = draw_gap();
    ev_held  = (next_gap == 0);
    if (!ev_held) ev_valid <= 1'b0;
  endtask

  // stop sending and wait until every command has come out
  task automatic drain_results();
    if (ev_held) begin
      ev_valid <= 1'b0;
      ev_held = 1'b0;
    end
    while (radio_cmds_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FINAL_DELAY:   reg_delay = data;
      REG_ANTENNA_DELAY: reg_antenna = data[15:0];
      REG_NOTICE_PERIOD: reg_period = data[7:0];
      default: ;
    endcase
  endtask

  // upper data bits are junk so the register widths get checked
  task automatic configure(input logic [31:0] delay, input logic [15:0] ant,
                           input logic [7:0] period);
    write_reg(REG_FINAL_DELAY, delay);
    write_reg(REG_ANTENNA_DELAY, {16'($urandom), ant});
    write_reg(REG_NOTICE_PERIOD, {24'($urandom), period});
    if ($urandom_range(0, 1) == 1) write_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed exchange with random content, some noise and misses
  task automatic run_exchange();
    int     pick;
    event_t e;
    send_event(rand_event(FUNC_START), 1'b0, '0);
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send_event(rand_event(FUNC_RX_FAIL), 1'b0, '0);
      return;
    end
    if (pick < 10) send_event(rand_event(3'($urandom)), 1'b0, '0);
    send_event(rand_event(FUNC_TX_DONE), 1'b0, '0);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_event(rand_event(FUNC_RX_FAIL), 1'b0, '0);
    end else begin
      if (pick < 15) send_event(rand_event(3'($urandom)), 1'b0, '0);
      e    = rand_event(FUNC_RX_GOOD);
      pick = $urandom_range(0, 99);
      if (pick < 55) e.rx_length = 10'($urandom_range(12, 1023));
      else if (pick < 75) e.rx_length = 10'($urandom_range(4, 11));
      else if (pick < 82) e.rx_length = 10'($urandom_range(0, 3));
      e.rx_type = ($urandom_range(0, 9) == 0) ? 8'($urandom) : MSG_TYPE_RESP;
      e.rx_seq  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : st_seq;
      send_event(e, 1'b0, '0);
    end
    if (st_phase == PH_FINAL_TX) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_event(rand_event(FUNC_START_LATE), 1'b0, '0);
      end else begin
        if (pick < 15) send_event(rand_event(3'($urandom)), 1'b0, '0);
        send_event(rand_event(FUNC_TX_DONE), 1'b0, '0);
      end
    end
  endtask

  // receiver: stall a random number of cycles after each result transfer
  always @(posedge clk) begin
    if (rst) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else if (res_valid && !res_stall) begin
      stall_draw = draw_gap();
      stall_left <= stall_draw;
      res_stall  <= (stall_draw != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      res_stall  <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // compare each result transfer with the oldest expected command
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (radio_cmds_q.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected, expected none actual %h",
                 $time, res_data);
      end else begin
        want_res = radio_cmds_q.pop_front();
        check_field("kind", 64'(want_res.kind), 64'(res_data.kind));
        check_field("out_seq", 64'(want_res.out_seq), 64'(res_data.out_seq));
        check_field("delayed_tx_word", 64'(want_res.delayed_tx_word),
                    64'(res_data.delayed_tx_word));
        check_field("poll_tx_time", 64'(want_res.poll_tx_time),
                    64'(res_data.poll_tx_time));
        check_field("resp_rx_time", 64'(want_res.resp_rx_time),
                    64'(res_data.resp_rx_time));
        check_field("remote_resp_tx_time", want_res.remote_resp_tx_time,
                    res_data.remote_resp_tx_time);
        check_field("final_tx_time", 64'(want_res.final_tx_time),
                    64'(res_data.final_tx_time));
      end
    end
  end

  initial begin
    // directed exchanges from reset with the default registers
    script.push_back('{mk_event(FUNC_START, '0, '0, '0, '0, '0, '0), 1'b1,
                       plain_result(KIND_SEND_POLL, 8'd0)});
    // response and start while the poll is still going out: ignored
    script.push_back('{mk_event(FUNC_RX_GOOD, '0, 40'h55_0000_0001, 10'd12, MSG_TYPE_RESP,
                                8'd0, 64'd1), 1'b0, '0});
    script.push_back('{mk_event(FUNC_START, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    // lost poll transmit-done, first miss gives a notice
    script.push_back('{mk_event(FUNC_RX_FAIL, '0, '0, '0, '0, '0, '0), 1'b1,
                       plain_result(KIND_NOTICE, 8'd0)});
    script.push_back('{mk_event(FUNC_START, '0, '0, '0, '0, '0, '0), 1'b1,
                       plain_result(KIND_SEND_POLL, 8'd1)});
    script.push_back('{mk_event(FUNC_TX_DONE, '1, '0, '0, '0, '0, '0), 1'b0, '0});
    // short frame
    script.push_back('{mk_event(FUNC_RX_GOOD, '0, '1, 10'd3, MSG_TYPE_RESP, 8'd1, '1),
                       1'b0, '0});
    script.push_back('{mk_event(FUNC_START, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    script.push_back('{mk_event(FUNC_TX_DONE, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    // wrong message type
    script.push_back('{mk_event(FUNC_RX_GOOD, '0, '1, 10'd12, 8'hFF, 8'd2, '1), 1'b0, '0});
    script.push_back('{mk_event(FUNC_START, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    script.push_back('{mk_event(FUNC_TX_DONE, 40'h12_3456_789A, '0, '0, '0, '0, '0),
                       1'b0, '0});
    // wrong sequence number
    script.push_back('{mk_event(FUNC_RX_GOOD, '0, '1, 10'd4, MSG_TYPE_RESP, 8'hFF, '1),
                       1'b0, '0});
    script.push_back('{mk_event(FUNC_START, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    script.push_back('{mk_event(FUNC_TX_DONE, '1, '0, '0, '0, '0, '0), 1'b0, '0});
    // longest frame, clipped, with the largest times so the word wraps
    script.push_back('{mk_event(FUNC_RX_GOOD, '0, '1, 10'h3FF, MSG_TYPE_RESP, 8'd4, '1),
                       1'b0, '0});
    script.push_back('{mk_event(FUNC_TX_DONE, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    script.push_back('{mk_event(FUNC_START, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    script.push_back('{mk_event(FUNC_TX_DONE, 40'h00_8000_0000, '0, '0, '0, '0, '0),
                       1'b0, '0});
    // response too short to carry the remote time
    script.push_back('{mk_event(FUNC_RX_GOOD, '0, '0, 10'd11, MSG_TYPE_RESP, 8'd5,
                                64'hA5A5_5A5A_A5A5_5A5A), 1'b0, '0});
    script.push_back('{mk_event(FUNC_START_LATE, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    // undefined codes and out-of-phase events in idle
    script.push_back('{mk_event(FUNC_UNDEF_LO, '1, '1, '1, '1, '1, '1), 1'b0, '0});
    script.push_back('{mk_event(FUNC_UNDEF_HI, '1, '1, '1, '1, '1, '1), 1'b0, '0});
    script.push_back('{mk_event(FUNC_RX_FAIL, '0, '0, '0, '0, '0, '0), 1'b0, '0});
    script.push_back('{mk_event(FUNC_TX_DONE, '1, '0, '0, '0, '0, '0), 1'b0, '0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) send_event(script[i].ev, script[i].typed, script[i].want);

    // random exchanges under several register settings
    for (phase_no = 1; phase_no <= 5; phase_no++) begin
      drain_results();
      case (phase_no)
        1: configure(32'hFFFF_FFFF, 16'hFFFF, 8'd1);
        2: configure(32'd0, 16'd0, 8'd0);
        3: configure($urandom, 16'($urandom), 8'd255);
        4: configure($urandom, 16'($urandom), 8'($urandom_range(2, 5)));
        default: configure(FINAL_DELAY_RST, 16'($urandom), 8'd3);
      endcase
      calm        = (phase_no == 5);
      start_items = items_sent;
      exchanges   = 0;
      while (items_sent - start_items < 150 || exchanges < 40) begin
        if (phase_no != 5 && $urandom_range(0, 15) == 0) calm = !calm;
        run_exchange();
        exchanges++;
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/twr_pkg.sv
hdl/twr_cfg_regs.sv
hdl/twr_in_stage.sv
hdl/twr_engine.sv
hdl/twr_out_stage.sv
hdl/twr_ranging_initiator.sv
sim/twr_ranging_initiator_tb.sv
